// ----- design/sorted_timeout_queue_assert.svh -----
`ifndef SORTED_TIMEOUT_QUEUE_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define STO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define STO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sto_pkg.sv -----
package sto_pkg;

	localparam int DELAY_W       = 30;
	localparam int FUNC_W        = 16;
	localparam int ARG_W         = 32;
	localparam int HANDLE_W      = 4;
	localparam int CMD_W         = 2;
	localparam int KIND_W        = 3;
	localparam int NUM_HANDLES   = 1 << HANDLE_W;
	localparam int DEPTH_DEF     = 16;
	localparam int TIME_BITS_DEF = 32;

	// stream beat layout
	localparam int IN_DELAY_LSB  = 0;
	localparam int IN_FUNC_LSB   = IN_DELAY_LSB + DELAY_W;
	localparam int IN_ARG_LSB    = IN_FUNC_LSB + FUNC_W;
	localparam int IN_HANDLE_LSB = IN_ARG_LSB + ARG_W;
	localparam int IN_BITS       = IN_HANDLE_LSB + HANDLE_W;
	localparam int S_TDATA_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS      = HANDLE_W + FUNC_W + ARG_W;
	localparam int M_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 2'd0,
		CMD_INSERT    = 2'd1,
		CMD_CANCEL_CB = 2'd2,
		CMD_CANCEL_H  = 2'd3
	} cmd_e;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERTED  = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_FIRED     = 3'd4
	} kind_e;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_e;

	typedef enum logic [1:0] {
		CH_HOLD,
		CH_INSERT,
		CH_REMOVE,
		CH_POP
	} chain_op_e;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [FUNC_W-1:0]   func_id;
		logic [ARG_W-1:0]    arg;
	} ent_t;

	typedef struct packed {
		logic                by_handle;
		logic [HANDLE_W-1:0] handle;
		logic [FUNC_W-1:0]   func_id;
		logic [ARG_W-1:0]    arg;
	} key_t;

	typedef struct packed {
		logic later;  // new deadline sorts ahead of this entry
		logic due;    // entry deadline reached
		logic hit;    // entry matches the cancel key
	} cell_stat_t;

	typedef struct packed {
		logic found;
		ent_t hit_ent;
		logic head_due;
		logic next_due;
		ent_t head_ent;
		logic full;
	} chain_stat_t;

endpackage

// ----- design/sto_cell.sv -----
module sto_cell
	import sto_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_op_e             op,
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] new_dl,
	input  ent_t                 new_ent,
	input  key_t                 key,
	input  logic                 left_valid,
	input  logic [TIME_BITS-1:0] left_dl,
	input  ent_t                 left_ent,
	input  logic                 right_valid,
	input  logic [TIME_BITS-1:0] right_dl,
	input  ent_t                 right_ent,
	output logic                 valid,
	output logic [TIME_BITS-1:0] dl,
	output ent_t                 ent,
	output cell_stat_t           stat
);

	logic                 valid_q;
	logic [TIME_BITS-1:0] dl_q;
	ent_t                 ent_q;
	logic [TIME_BITS-1:0] later_diff;
	logic [TIME_BITS-1:0] due_diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				CELL_LOAD:       valid_q <= 1'b1;
				CELL_FROM_LEFT:  valid_q <= left_valid;
				CELL_FROM_RIGHT: valid_q <= right_valid;
				default:         valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: begin
				dl_q  <= new_dl;
				ent_q <= new_ent;
			end
			CELL_FROM_LEFT: begin
				dl_q  <= left_dl;
				ent_q <= left_ent;
			end
			CELL_FROM_RIGHT: begin
				dl_q  <= right_dl;
				ent_q <= right_ent;
			end
			default: begin
				dl_q  <= dl_q;
				ent_q <= ent_q;
			end
		endcase
	end

	// wrap-safe compares: sign of the modular difference
	assign later_diff = new_dl - dl_q;
	assign due_diff   = now - dl_q;

	always_comb begin
		stat.later = valid_q && later_diff[TIME_BITS-1];
		stat.due   = valid_q && !due_diff[TIME_BITS-1];
		if (key.by_handle) begin
			stat.hit = valid_q && (ent_q.handle == key.handle);
		end else begin
			stat.hit = valid_q && (ent_q.func_id == key.func_id) && (ent_q.arg == key.arg);
		end
	end

	assign valid = valid_q;
	assign dl    = dl_q;
	assign ent   = ent_q;

endmodule

// ----- design/sto_chain.sv -----
module sto_chain
	import sto_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chain_op_e            cmd,
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] new_dl,
	input  ent_t                 new_ent,
	input  key_t                 key,
	output chain_stat_t          stat
);

	// no more entries than handles can ever be live
	localparam int CELLS = (DEPTH < NUM_HANDLES) ? DEPTH : NUM_HANDLES;

	logic [CELLS-1:0]     v;
	logic [TIME_BITS-1:0] dl_w   [CELLS];
	ent_t                 ent_w  [CELLS];
	cell_stat_t           cst    [CELLS];
	cell_op_e             ops    [CELLS];

	logic [TIME_BITS-1:0] lt_dl  [CELLS];
	ent_t                 lt_ent [CELLS];
	logic [CELLS-1:0]     lt_v;
	logic [TIME_BITS-1:0] rt_dl  [CELLS];
	ent_t                 rt_ent [CELLS];
	logic [CELLS-1:0]     rt_v;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lt_v[i]   = 1'b0;
			assign lt_dl[i]  = '0;
			assign lt_ent[i] = '0;
		end else begin : g_mid
			assign lt_v[i]   = v[i-1];
			assign lt_dl[i]  = dl_w[i-1];
			assign lt_ent[i] = ent_w[i-1];
		end
		if (i == CELLS - 1) begin : g_last
			assign rt_v[i]   = 1'b0;
			assign rt_dl[i]  = '0;
			assign rt_ent[i] = '0;
		end else begin : g_inner
			assign rt_v[i]   = v[i+1];
			assign rt_dl[i]  = dl_w[i+1];
			assign rt_ent[i] = ent_w[i+1];
		end

		sto_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (ops[i]),
			.now         (now),
			.new_dl      (new_dl),
			.new_ent     (new_ent),
			.key         (key),
			.left_valid  (lt_v[i]),
			.left_dl     (lt_dl[i]),
			.left_ent    (lt_ent[i]),
			.right_valid (rt_v[i]),
			.right_dl    (rt_dl[i]),
			.right_ent   (rt_ent[i]),
			.valid       (v[i]),
			.dl          (dl_w[i]),
			.ent         (ent_w[i]),
			.stat        (cst[i])
		);
	end

	// insert point: first entry that sorts later, else first empty slot;
	// remove point: first key match
	always_comb begin
		logic seen_ins;
		logic seen_hit;
		logic slot;
		ent_t hit_ent;
		seen_ins = 1'b0;
		seen_hit = 1'b0;
		hit_ent  = '0;
		for (int i = 0; i < CELLS; i++) begin
			slot = cst[i].later || !v[i];
			case (cmd)
				CH_INSERT: ops[i] = seen_ins ? CELL_FROM_LEFT : (slot ? CELL_LOAD : CELL_HOLD);
				CH_REMOVE: ops[i] = (seen_hit || cst[i].hit) ? CELL_FROM_RIGHT : CELL_HOLD;
				CH_POP:    ops[i] = CELL_FROM_RIGHT;
				default:   ops[i] = CELL_HOLD;
			endcase
			if (cst[i].hit && !seen_hit) begin
				hit_ent = ent_w[i];
			end
			seen_ins = seen_ins || slot;
			seen_hit = seen_hit || cst[i].hit;
		end
		stat.found    = seen_hit;
		stat.hit_ent  = hit_ent;
		stat.head_due = cst[0].due;
		stat.next_due = cst[1].due;
		stat.head_ent = ent_w[0];
		stat.full     = v[CELLS-1];
	end

endmodule

// ----- design/sorted_timeout_queue.sv -----
// Channel   Dir  tdata (low bit up)                         tuser     tlast
// s_*       in   delay[29:0] func_id[45:30] arg[77:46]      command   -
//                handle[81:78], zero pad to 88
// m_*       out  handle_res[3:0] func_id_res[19:4]          kind      last
//                arg_res[51:20], zero pad to 56
//
// An insert or cancel takes the beat in ST_IDLE, then runs the cell chain in
// ST_EXEC. A tick stays in ST_EXEC until no entry is due, since the head cell
// of the chain retires a single entry each cycle when the output is free.
// Work halts while the output register holds a beat that is not taken.
// After reset the queue is empty and the time count is zero.
module sorted_timeout_queue
	import sto_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // delay, func_id, arg, handle
	input  logic [CMD_W-1:0]     s_tuser,   // command
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // handle_res, func_id_res, arg_res
	output logic [KIND_W-1:0]    m_tuser,   // kind
	output logic                 m_tlast
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_e;

	state_e                   state_q;
	cmd_e                     cmd_q;
	key_t                     key_q;
	logic [TIME_BITS-1:0]     new_dl_q;
	logic [TIME_BITS-1:0]     now_q;
	logic [NUM_HANDLES-1:0]   in_use_q;
	logic                     out_valid_q;
	kind_e                    out_kind_q;
	ent_t                     out_ent_q;
	logic                     out_last_q;

	cmd_e                     s_cmd;
	logic [DELAY_W-1:0]       s_delay;
	logic [DELAY_W-1:0]       delay_nz;
	logic [TIME_BITS+DELAY_W-1:0] delay_wide;
	logic [TIME_BITS-1:0]     delay_t;
	logic                     out_free;
	logic                     out_load;
	logic                     free_found;
	logic [HANDLE_W-1:0]      free_h;
	logic                     ins_full;
	chain_op_e                chain_op;
	chain_stat_t              cstat;
	ent_t                     new_ent;

	assign s_cmd      = cmd_e'(s_tuser);
	assign s_delay    = s_tdata[IN_DELAY_LSB +: DELAY_W];
	assign delay_nz   = (s_delay == '0) ? DELAY_W'(1) : s_delay;
	assign delay_wide = {{TIME_BITS{1'b0}}, delay_nz};
	assign delay_t    = delay_wide[TIME_BITS-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	// a tick with nothing due retires without a beat
	assign out_load = (state_q == ST_EXEC) && out_free &&
		((cmd_q != CMD_TICK) || cstat.head_due);

	always_comb begin
		free_found = 1'b0;
		free_h     = '0;
		for (int i = 0; i < NUM_HANDLES; i++) begin
			if (!in_use_q[i] && !free_found) begin
				free_found = 1'b1;
				free_h     = HANDLE_W'(i);
			end
		end
	end

	assign ins_full = cstat.full || !free_found;

	assign new_ent.handle  = free_h;
	assign new_ent.func_id = key_q.func_id;
	assign new_ent.arg     = key_q.arg;

	always_comb begin
		chain_op = CH_HOLD;
		if (state_q == ST_EXEC && out_free) begin
			case (cmd_q)
				CMD_TICK:      chain_op = cstat.head_due ? CH_POP : CH_HOLD;
				CMD_INSERT:    chain_op = ins_full ? CH_HOLD : CH_INSERT;
				CMD_CANCEL_CB,
				CMD_CANCEL_H:  chain_op = cstat.found ? CH_REMOVE : CH_HOLD;
				default:       chain_op = CH_HOLD;
			endcase
		end
	end

	sto_chain #(
		.DEPTH     (DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (chain_op),
		.now     (now_q),
		.new_dl  (new_dl_q),
		.new_ent (new_ent),
		.key     (key_q),
		.stat    (cstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_TICK;
			key_q       <= '0;
			new_dl_q    <= '0;
			now_q       <= '0;
			in_use_q    <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_INSERTED;
			out_ent_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q           <= s_cmd;
						key_q.by_handle <= (s_cmd == CMD_CANCEL_H);
						key_q.handle    <= s_tdata[IN_HANDLE_LSB +: HANDLE_W];
						key_q.func_id   <= s_tdata[IN_FUNC_LSB +: FUNC_W];
						key_q.arg       <= s_tdata[IN_ARG_LSB +: ARG_W];
						new_dl_q        <= now_q + delay_t;
						if (s_cmd == CMD_TICK) begin
							now_q <= now_q + TIME_BITS'(1);
						end
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						case (cmd_q)
							CMD_TICK: begin
								if (cstat.head_due) begin
									out_kind_q                     <= KIND_FIRED;
									out_ent_q                      <= cstat.head_ent;
									out_last_q                     <= !cstat.next_due;
									in_use_q[cstat.head_ent.handle] <= 1'b0;
									if (!cstat.next_due) begin
										state_q <= ST_IDLE;
									end
								end else begin
									state_q <= ST_IDLE;
								end
							end
							CMD_INSERT: begin
								out_last_q  <= 1'b1;
								if (ins_full) begin
									out_kind_q <= KIND_FULL;
									out_ent_q  <= '0;
								end else begin
									out_kind_q       <= KIND_INSERTED;
									out_ent_q        <= '{handle: free_h, func_id: '0, arg: '0};
									in_use_q[free_h] <= 1'b1;
								end
								state_q <= ST_IDLE;
							end
							default: begin
								out_last_q  <= 1'b1;
								if (cstat.found) begin
									out_kind_q                     <= KIND_CANCELLED;
									out_ent_q                      <= cstat.hit_ent;
									in_use_q[cstat.hit_ent.handle] <= 1'b0;
								end else begin
									out_kind_q <= KIND_NOT_FOUND;
									out_ent_q  <= '0;
								end
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_ent_q.arg, out_ent_q.func_id, out_ent_q.handle});
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- design/sto_checker.sv -----
`include "sorted_timeout_queue_assert.svh"

module sto_checker
	import sto_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]    m_tuser,
	input logic                 m_tlast
);

	// hold a stalled result beat
	`STO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")

	// only fired beats may leave the run open
	`STO_ASSERT_NOW(a_single_last, m_tvalid && (m_tuser != KIND_FIRED), m_tlast, "insert or cancel result without last")

	// drop payload on full and not-found answers
	`STO_ASSERT_NOW(a_empty_payload, m_tvalid && ((m_tuser == KIND_FULL) || (m_tuser == KIND_NOT_FOUND)), m_tdata == '0, "full or not-found beat carries payload")

	// an insert answer carries the handle only
	`STO_ASSERT_NOW(a_insert_payload, m_tvalid && (m_tuser == KIND_INSERTED), m_tdata[M_TDATA_W-1:HANDLE_W] == '0, "insert beat carries callback fields")

	// hold off the input while a beat is being worked on
	`STO_ASSERT_NEXT(a_in_one_beat, s_tvalid && s_tready, !s_tready, "input ready right after a taken beat")

endmodule

bind sorted_timeout_queue sto_checker u_sto_checker (.*);
